@@ src/dho_pkg.sv @@
// types, constants and the month offset table for the date hour offset core
package dho_pkg;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_MONTH   = 3'd1,
        ST_BAD_DAY     = 3'd2,
        ST_BAD_HOUR    = 3'd3,
        ST_THIRTY_DAY  = 3'd4,
        ST_LEAP_FEB    = 3'd5,
        ST_COMMON_FEB  = 3'd6,
        ST_YEAR_RANGE  = 3'd7
    } status_t;

    // configuration register indexes
    localparam logic CFG_YEAR_DIGITS_MODE = 1'b0;
    localparam logic CFG_MAX_YEAR         = 1'b1;

    // year digit modes
    localparam logic [1:0] MODE_FOLLOW     = 2'd0;
    localparam logic [1:0] MODE_TWO_DIGIT  = 2'd1;
    localparam logic [1:0] MODE_FOUR_DIGIT = 2'd2;

    localparam logic [13:0] MAX_YEAR_RESET = 14'd2050;
    localparam logic [13:0] MAX_YEAR_LOW   = 14'd1100;
    localparam logic [13:0] MAX_YEAR_HIGH  = 14'd9899;
    localparam logic [13:0] WINDOW_YEARS   = 14'd100;
    localparam logic [13:0] FULL_YEAR_MIN  = 14'd1000;

    // reciprocals: ceil(2^20/100), ceil(2^21/3), ceil(2^16/30), floor(2^24*400/146097)
    localparam logic [13:0] RECIP_100  = 14'd10486;
    localparam logic [20:0] RECIP_3    = 21'd699051;
    localparam logic [11:0] RECIP_30   = 12'd2185;
    localparam logic [15:0] YEAR_RECIP = 16'd45934;
    localparam logic [17:0] DAYS_400Y  = 18'd146097;

    // bias that keeps the hours/8 value positive before the divide by three
    localparam logic signed [19:0] DIV3_BIAS = 20'sd196608;
    localparam logic signed [17:0] DAY_BIAS  = 18'sd65536;

    localparam logic signed [24:0] MARCH_LAST = 25'sd59;
    localparam logic signed [10:0] YEAR_DAYS  = 11'sd365;

    // day offset of each month in a march based year, plus one closing entry
    function automatic logic [8:0] cum_days(input logic [3:0] idx);
        logic [8:0] val;
        case (idx)
            4'd0:    val = 9'd365;
            4'd1:    val = 9'd396;
            4'd2:    val = 9'd59;
            4'd3:    val = 9'd90;
            4'd4:    val = 9'd120;
            4'd5:    val = 9'd151;
            4'd6:    val = 9'd181;
            4'd7:    val = 9'd212;
            4'd8:    val = 9'd243;
            4'd9:    val = 9'd273;
            4'd10:   val = 9'd304;
            4'd11:   val = 9'd334;
            4'd12:   val = 9'd365;
            default: val = 9'd0;
        endcase
        return val;
    endfunction

    typedef struct packed {
        logic              full;
        logic              windowed;
        logic              feb;
        logic [13:0]       top;
        logic [13:0]       diff;
        logic [13:0]       iyy;
        logic [6:0]        imm;
        logic [6:0]        idd;
        status_t           status;
        logic [18:0]       u;
        logic [2:0]        low3;
        logic [6:0]        dq;
        logic [16:0]       q3;
        logic [13:0]       jyy;
        logic signed [17:0] kdd;
        logic [4:0]        jh;
        logic [7:0]        jq;
        logic [13:0]       yadj;
        logic [7:0]        qa;
        logic [23:0]       db;
        logic [23:0]       mday;
        logic [14:0]       q0;
        logic [32:0]       pq;
        logic [32:0]       n400;
        logic [14:0]       q;
        logic [7:0]        qq;
        logic [7:0]        qm;
        logic [23:0]       dbq;
        logic [23:0]       dbm;
        logic [14:0]       yr;
        logic signed [10:0] md;
        logic [3:0]        jm;
        logic [4:0]        jd;
        logic              year_ok;
        logic [7:0]        yq;
    } pipe_t;

endpackage

@@ src/date_hour_offset_core.sv @@
// date hour offset core: shifts a date and hour by a signed number of hours
//
//  channel   | handshake          | fields
//  ----------+--------------------+---------------------------------------------
//  request   | start, busy        | year_in, month_in, day_in, hour_in, hour_offset
//  result    | done (one cycle)   | year_out, month_out, day_out, hour_out,
//            |                    | year_is_full, status
//  config    | wr_en              | wr_index, wr_data
//
// a request is taken every cycle, and results leave in the order of their requests.
// the pipeline has sixteen register stages, counting the output registers, with
// constant multiplies or wide adds in each (year recovery needs three of them).
// busy stays low: nothing downstream can hold results off, so nothing stalls.
// reset clears the stage valid bits and loads the configuration defaults.
module date_hour_offset_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [13:0]        year_in,
    input  logic [6:0]         month_in,
    input  logic [6:0]         day_in,
    input  logic [6:0]         hour_in,
    input  logic signed [20:0] hour_offset,
    output logic               done,
    output logic [13:0]        year_out,
    output logic [3:0]         month_out,
    output logic [4:0]         day_out,
    output logic [4:0]         hour_out,
    output logic               year_is_full,
    output logic [2:0]         status,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [13:0]        wr_data
);

    localparam int NUM_STAGES = 15;

    logic [1:0]  mode_reg;
    logic [13:0] max_year_reg;

    dho_pkg::pipe_t stg_reg  [1:NUM_STAGES];
    dho_pkg::pipe_t stg_next [1:NUM_STAGES];
    logic [NUM_STAGES:1] vld_reg;

    logic [13:0] year_out_reg,  year_out_next;
    logic [3:0]  month_out_reg, month_out_next;
    logic [4:0]  day_out_reg,   day_out_next;
    logic [4:0]  hour_out_reg,  hour_out_next;
    logic        full_reg,      full_next;
    dho_pkg::status_t status_reg, status_next;
    logic        done_reg;

    // stage temporaries
    logic [13:0]        top_sat;
    logic signed [21:0] total;
    logic signed [19:0] div3_src;
    logic [27:0]        prod_dq;
    logic [39:0]        prod_q3;
    logic [13:0]        wmod;
    logic [18:0]        rem3;
    logic [27:0]        prod_jq;
    logic [13:0]        r100;
    logic               leap;
    logic               early_year;
    logic signed [25:0] mday_sum;
    logic [38:0]        prod_y;
    logic [32:0]        rem_y;
    logic [28:0]        prod_qq;
    logic [28:0]        prod_qm;
    logic [14:0]        q_less;
    logic [14:0]        q_less12;
    logic signed [24:0] t_day;
    logic signed [24:0] t_prev;
    logic [20:0]        prod_jm;
    logic [8:0]         cum_a;
    logic [3:0]         jm_fix;
    logic [8:0]         cum_b;
    logic [29:0]        prod_yq;

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= dho_pkg::MODE_FOLLOW;
            max_year_reg <= dho_pkg::MAX_YEAR_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                dho_pkg::CFG_YEAR_DIGITS_MODE: mode_reg     <= wr_data[1:0];
                dho_pkg::CFG_MAX_YEAR:         max_year_reg <= wr_data;
                default:                       mode_reg     <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        // stage 1: window limits, input checks, hour sum
        if (max_year_reg < dho_pkg::MAX_YEAR_LOW)
            top_sat = dho_pkg::MAX_YEAR_LOW;
        else if (max_year_reg > dho_pkg::MAX_YEAR_HIGH)
            top_sat = dho_pkg::MAX_YEAR_HIGH;
        else
            top_sat = max_year_reg;

        total    = $signed({hour_offset[20], hour_offset}) + $signed({15'd0, hour_in});
        div3_src = 20'(total >>> 3) + dho_pkg::DIV3_BIAS;

        stg_next[1]          = '0;
        stg_next[1].top      = top_sat;
        stg_next[1].diff     = top_sat - year_in;
        stg_next[1].windowed = (year_in < dho_pkg::FULL_YEAR_MIN);
        stg_next[1].iyy      = year_in;
        stg_next[1].imm      = month_in;
        stg_next[1].idd      = day_in;
        stg_next[1].u        = div3_src[18:0];
        stg_next[1].low3     = total[2:0];
        case (mode_reg)
            dho_pkg::MODE_FOUR_DIGIT: stg_next[1].full = 1'b1;
            dho_pkg::MODE_TWO_DIGIT:  stg_next[1].full = 1'b0;
            default:                  stg_next[1].full = (year_in >= dho_pkg::FULL_YEAR_MIN);
        endcase
        if (!(month_in inside {[7'd1:7'd12]}))
            stg_next[1].status = dho_pkg::ST_BAD_MONTH;
        else if (!(day_in inside {[7'd1:7'd31]}))
            stg_next[1].status = dho_pkg::ST_BAD_DAY;
        else if (hour_in > 7'd23)
            stg_next[1].status = dho_pkg::ST_BAD_HOUR;
        else if ((month_in inside {7'd4, 7'd6, 7'd9, 7'd11}) && day_in > 7'd30)
            stg_next[1].status = dho_pkg::ST_THIRTY_DAY;
        else
            stg_next[1].status = dho_pkg::ST_OK;
        stg_next[1].feb = (month_in == 7'd2);

        // stage 2: window remainder quotient, hours/24 quotient
        stg_next[2]    = stg_reg[1];
        prod_dq        = 28'(stg_reg[1].diff) * 28'(dho_pkg::RECIP_100);
        stg_next[2].dq = prod_dq[26:20];
        prod_q3        = 40'(stg_reg[1].u) * 40'(dho_pkg::RECIP_3);
        stg_next[2].q3 = prod_q3[37:21];

        // stage 3: windowed year, day count and hour of the shift
        stg_next[3]     = stg_reg[2];
        wmod            = stg_reg[2].diff - 14'(stg_reg[2].dq) * 14'd100;
        stg_next[3].jyy = stg_reg[2].windowed ? stg_reg[2].top - wmod : stg_reg[2].iyy;
        stg_next[3].kdd = $signed({1'b0, stg_reg[2].q3}) - dho_pkg::DAY_BIAS;
        rem3            = stg_reg[2].u - 19'(stg_reg[2].q3) * 19'd3;
        stg_next[3].jh  = {rem3[1:0], stg_reg[2].low3};

        // stage 4: century of the windowed year
        stg_next[4]    = stg_reg[3];
        prod_jq        = 28'(stg_reg[3].jyy) * 28'(dho_pkg::RECIP_100);
        stg_next[4].jq = prod_jq[27:20];

        // stage 5: leap rule, february checks, march based year
        stg_next[5] = stg_reg[4];
        r100        = stg_reg[4].jyy - 14'(stg_reg[4].jq) * 14'd100;
        leap        = (stg_reg[4].jyy[1:0] == 2'd0) &&
                      ((r100 != 14'd0) || (stg_reg[4].jq[1:0] == 2'd0));
        if (stg_reg[4].status == dho_pkg::ST_OK && stg_reg[4].feb)
        begin
            if (leap && stg_reg[4].idd > 7'd29)
                stg_next[5].status = dho_pkg::ST_LEAP_FEB;
            else if (!leap && stg_reg[4].idd > 7'd28)
                stg_next[5].status = dho_pkg::ST_COMMON_FEB;
        end
        early_year       = (stg_reg[4].imm < 7'd3);
        stg_next[5].yadj = stg_reg[4].jyy - 14'(early_year);
        stg_next[5].qa   = (early_year && r100 == 14'd0) ? stg_reg[4].jq - 8'd1
                                                         : stg_reg[4].jq;

        // stage 6: day number of the year start
        stg_next[6]    = stg_reg[5];
        stg_next[6].db = 24'(stg_reg[5].yadj) * 24'd365 + 24'(stg_reg[5].yadj >> 2)
                       - 24'(stg_reg[5].qa) + 24'(stg_reg[5].qa >> 2);

        // stage 7: shifted day number
        stg_next[7]      = stg_reg[6];
        mday_sum         = $signed({2'b0, stg_reg[6].db})
                         + $signed({17'b0, dho_pkg::cum_days(4'(stg_reg[6].imm - 7'd1))})
                         + $signed({19'b0, stg_reg[6].idd})
                         + 26'(stg_reg[6].kdd);
        stg_next[7].mday = mday_sum[23:0];

        // stage 8: year estimate, low by at most one
        stg_next[8]    = stg_reg[7];
        prod_y         = 39'(stg_reg[7].mday[22:0]) * 39'(dho_pkg::YEAR_RECIP);
        stg_next[8].q0 = prod_y[38:24];

        // stage 9: products for the estimate check
        stg_next[9]      = stg_reg[8];
        stg_next[9].pq   = 33'(stg_reg[8].q0) * 33'(dho_pkg::DAYS_400Y);
        stg_next[9].n400 = 33'(stg_reg[8].mday) * 33'd400;

        // stage 10: exact quotient of the day number by 365.2425
        stg_next[10]   = stg_reg[9];
        rem_y          = stg_reg[9].n400 - stg_reg[9].pq;
        stg_next[10].q = stg_reg[9].q0 + 15'(rem_y >= 33'(dho_pkg::DAYS_400Y));

        // stage 11: centuries of the year and the year before
        stg_next[11]    = stg_reg[10];
        q_less          = stg_reg[10].q - 15'd1;
        prod_qq         = 29'(stg_reg[10].q) * 29'(dho_pkg::RECIP_100);
        prod_qm         = 29'(q_less) * 29'(dho_pkg::RECIP_100);
        stg_next[11].qq = prod_qq[27:20];
        stg_next[11].qm = prod_qm[27:20];

        // stage 12: year start day numbers for both candidates
        stg_next[12]     = stg_reg[11];
        q_less12         = stg_reg[11].q - 15'd1;
        stg_next[12].dbq = 24'(stg_reg[11].q) * 24'd365 + 24'(stg_reg[11].q >> 2)
                         - 24'(stg_reg[11].qq) + 24'(stg_reg[11].qq >> 2);
        stg_next[12].dbm = 24'(q_less12) * 24'd365 + 24'(q_less12 >> 2)
                         - 24'(stg_reg[11].qm) + 24'(stg_reg[11].qm >> 2);

        // stage 13: pick the year, day of march based year
        stg_next[13] = stg_reg[12];
        t_day        = $signed({1'b0, stg_reg[12].mday}) - $signed({1'b0, stg_reg[12].dbq});
        t_prev       = $signed({1'b0, stg_reg[12].mday}) - $signed({1'b0, stg_reg[12].dbm});
        if (t_day <= dho_pkg::MARCH_LAST)
        begin
            stg_next[13].yr = stg_reg[12].q - 15'd1;
            stg_next[13].md = 11'(t_prev);
        end
        else
        begin
            stg_next[13].yr = stg_reg[12].q;
            stg_next[13].md = 11'(t_day);
        end

        // stage 14: month estimate, january and february close the year
        stg_next[14] = stg_reg[13];
        prod_jm      = 21'(stg_reg[13].md[8:0]) * 21'(dho_pkg::RECIP_30);
        if (stg_reg[13].md > dho_pkg::YEAR_DAYS)
        begin
            stg_next[14].jm = 4'd2;
            stg_next[14].yr = stg_reg[13].yr + 15'd1;
        end
        else if (stg_reg[13].md < 11'sd0)
            stg_next[14].jm = 4'd1;
        else
            stg_next[14].jm = 4'(prod_jm[20:16]) + 4'd1;

        // stage 15: month fix up, day, year window check
        stg_next[15] = stg_reg[14];
        cum_a        = dho_pkg::cum_days(stg_reg[14].jm - 4'd1);
        if ((stg_reg[14].md - $signed({2'b0, cum_a})) <= 11'sd0 && stg_reg[14].jm > 4'd1)
            jm_fix = stg_reg[14].jm - 4'd1;
        else
            jm_fix = stg_reg[14].jm;
        cum_b                = dho_pkg::cum_days(jm_fix - 4'd1);
        stg_next[15].jm      = jm_fix;
        stg_next[15].jd      = 5'(stg_reg[14].md - $signed({2'b0, cum_b}));
        stg_next[15].year_ok = !((stg_reg[14].yr > {1'b0, stg_reg[14].top}) ||
                                 (stg_reg[14].yr < {1'b0, stg_reg[14].top
                                                          - dho_pkg::WINDOW_YEARS}));
        prod_yq              = 30'(stg_reg[14].yr) * 30'(dho_pkg::RECIP_100);
        stg_next[15].yq      = prod_yq[27:20];

        // output stage: error results carry zeros
        year_out_next  = '0;
        month_out_next = '0;
        day_out_next   = '0;
        hour_out_next  = '0;
        full_next      = 1'b0;
        status_next    = stg_reg[15].status;
        if (stg_reg[15].status == dho_pkg::ST_OK)
        begin
            if (!stg_reg[15].year_ok)
                status_next = dho_pkg::ST_YEAR_RANGE;
            else
            begin
                year_out_next  = stg_reg[15].full ? stg_reg[15].yr[13:0]
                               : 14'(stg_reg[15].yr - 15'(stg_reg[15].yq) * 15'd100);
                month_out_next = stg_reg[15].jm;
                day_out_next   = stg_reg[15].jd;
                hour_out_next  = stg_reg[15].jh;
                full_next      = stg_reg[15].full;
            end
        end
    end

    // stage valid bits and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[NUM_STAGES-1:1], start & ~busy};
            done_reg <= vld_reg[NUM_STAGES];
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        for (int i = 1; i <= NUM_STAGES; i++)
        begin
            stg_reg[i] <= stg_next[i];
        end
        year_out_reg  <= year_out_next;
        month_out_reg <= month_out_next;
        day_out_reg   <= day_out_next;
        hour_out_reg  <= hour_out_next;
        full_reg      <= full_next;
        status_reg    <= status_next;
    end

    assign done         = done_reg;
    assign year_out     = year_out_reg;
    assign month_out    = month_out_reg;
    assign day_out      = day_out_reg;
    assign hour_out     = hour_out_reg;
    assign year_is_full = full_reg;
    assign status       = status_reg;

endmodule
